// ----- hdl/sld_pkg.sv -----
// ----------------------------------------------------------------------------
// sld_pkg
// Shared constants, codes and types of the serial line discipline buffer.
// ----------------------------------------------------------------------------
package sld_pkg;

   // Ring size and the widths that follow from it
   localparam int BUF_DEPTH = 64;
   localparam int PTR_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

   // Character codes
   localparam logic [7:0] CH_NL  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_DEL = 8'h7F;

   // Result kinds
   localparam logic [1:0] KIND_ECHO      = 2'd0;
   localparam logic [1:0] KIND_STATUS    = 2'd1;
   localparam logic [1:0] KIND_DATA      = 2'd2;
   localparam logic [1:0] KIND_NOT_READY = 2'd3;

   // Input item modes
   localparam logic MODE_RX   = 1'b0;
   localparam logic MODE_READ = 1'b1;

   // Most results caused by one item
   localparam int MAX_RES = 3;
   localparam int RES_W   = $clog2(MAX_RES);

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_EMIT
   } sld_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;     // take the item and fetch the ring byte it needs
      logic exec;     // update the ring state and build the results
      logic advance;  // step to the next result
   } sld_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic at_last;  // the result shown is the final one of the item
   } sld_sts_type;

endpackage

// ----- hdl/sld_if.sv -----
// ----------------------------------------------------------------------------
// sld channel interfaces
// Valid/ready channels for requests, responses and the control register.
// ----------------------------------------------------------------------------
interface sld_req_if
   import sld_pkg::*;
();
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] rx_byte;

   modport source (output valid, output mode, output rx_byte, input ready);
   modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface sld_rsp_if
   import sld_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [1:0]       kind;
   logic [7:0]       data_byte;
   logic             last;
   logic             overflow_error;
   logic [CNT_W-1:0] chars_held;
   logic [CNT_W-1:0] lines_held;

   modport source (output valid, output kind, output data_byte, output last,
                   output overflow_error, output chars_held, output lines_held,
                   input ready);
   modport sink   (input valid, input kind, input data_byte, input last,
                   input overflow_error, input chars_held, input lines_held,
                   output ready);
endinterface

interface sld_csr_if
   import sld_pkg::*;
();
   logic valid;
   logic ready;
   logic text_input;

   modport source (output valid, output text_input, input ready);
   modport sink   (input valid, input text_input, output ready);
endinterface

// ----- hdl/sld_ctrl.sv -----
// ----------------------------------------------------------------------------
// sld_ctrl
// Sequencing state machine: accept, execute, then hand out the results.
// ----------------------------------------------------------------------------
module sld_ctrl
   import sld_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output sld_cmd_type cmd,
   input  sld_sts_type sts
);

   sld_state_type state_ff;
   sld_state_type state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready && sts.at_last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.load    = 1'b0;
      cmd.exec    = 1'b0;
      cmd.advance = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid   = 1'b1;
            cmd.advance = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ----- hdl/sld_dpath.sv -----
// ----------------------------------------------------------------------------
// sld_dpath
// Ring memory, pointers, counters, error flag and the result list.
// ----------------------------------------------------------------------------
module sld_dpath
   import sld_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  sld_cmd_type      cmd,
   output sld_sts_type      sts,
   // request payload
   input  logic             req_mode,
   input  logic [7:0]       req_rx_byte,
   // control register
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_text_input,
   // result payload
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_last,
   output logic             rsp_overflow_error,
   output logic [CNT_W-1:0] rsp_chars_held,
   output logic [CNT_W-1:0] rsp_lines_held
);

   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(BUF_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(BUF_DEPTH);
   localparam logic [CNT_W-1:0] CNT_TEXT  = CNT_W'(BUF_DEPTH - 1);
   localparam logic [RES_W-1:0] RES_FIRST = RES_W'(0);

   logic [7:0]       ring_mem [BUF_DEPTH];
   logic [7:0]       rd_data_ff;

   logic             text_input_ff;
   logic             mode_ff;
   logic [7:0]       byte_ff;
   logic [PTR_W-1:0] wr_pos_ff, wr_pos_in;
   logic [PTR_W-1:0] rd_pos_ff, rd_pos_in;
   logic [CNT_W-1:0] byte_cnt_ff, byte_cnt_in;
   logic [CNT_W-1:0] line_cnt_ff, line_cnt_in;
   logic             err_ff, err_in;
   logic [1:0]       res_kind_ff [MAX_RES];
   logic [1:0]       res_kind_in [MAX_RES];
   logic [7:0]       res_data_ff [MAX_RES];
   logic [7:0]       res_data_in [MAX_RES];
   logic [RES_W-1:0] last_idx_ff, last_idx_in;
   logic [RES_W-1:0] idx_ff, idx_in;

   logic [PTR_W-1:0] wr_prev;
   logic [PTR_W-1:0] wr_next;
   logic [PTR_W-1:0] rd_next;
   logic [PTR_W-1:0] rd_addr;
   logic             mem_we;
   logic [7:0]       mem_wdata;
   logic             is_full;
   logic             text_room;
   logic             is_nl_cr;
   logic             is_erase;
   logic             read_ok;

   // Wrap the pointers at the ring depth
   assign wr_prev = (wr_pos_ff == '0) ? PTR_LAST : wr_pos_ff - PTR_W'(1);
   assign wr_next = (wr_pos_ff == PTR_LAST) ? '0 : wr_pos_ff + PTR_W'(1);
   assign rd_next = (rd_pos_ff == PTR_LAST) ? '0 : rd_pos_ff + PTR_W'(1);

   // Fetch the head byte for a read, or the last stored byte for an erase
   assign rd_addr = (req_mode == MODE_READ) ? rd_pos_ff : wr_prev;

   always_ff @(posedge clock) begin
      if (mem_we) ring_mem[wr_pos_ff] <= mem_wdata;
      if (cmd.load) rd_data_ff <= ring_mem[rd_addr];
   end

   // Capture the transaction payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         byte_ff <= req_rx_byte;
      end
   end

   // Take control register writes
   assign csr_ready = 1'b1;

   assign is_full   = (byte_cnt_ff == CNT_FULL);
   assign text_room = (byte_cnt_ff < CNT_TEXT);
   assign is_nl_cr  = (byte_ff == CH_NL) || (byte_ff == CH_CR);
   assign is_erase  = (byte_ff == CH_BS) || (byte_ff == CH_DEL);
   assign read_ok   = (byte_cnt_ff != '0) &&
                      (text_input_ff ? (line_cnt_ff != '0) : 1'b1);

   // Work out the new ring state and the result list of one item
   always_comb begin
      wr_pos_in   = wr_pos_ff;
      rd_pos_in   = rd_pos_ff;
      byte_cnt_in = byte_cnt_ff;
      line_cnt_in = line_cnt_ff;
      err_in      = err_ff;
      mem_we      = 1'b0;
      mem_wdata   = byte_ff;
      last_idx_in = RES_FIRST;
      for (int i = 0; i < MAX_RES; i++) begin
         res_kind_in[i] = KIND_STATUS;
         res_data_in[i] = 8'h00;
      end

      if (cmd.exec) begin
         priority if (mode_ff == MODE_READ) begin
            if (read_ok) begin
               rd_pos_in      = rd_next;
               byte_cnt_in    = byte_cnt_ff - CNT_W'(1);
               if ((rd_data_ff == CH_NL) && (line_cnt_ff != '0)) begin
                  line_cnt_in = line_cnt_ff - CNT_W'(1);
               end
               res_kind_in[0] = KIND_DATA;
               res_data_in[0] = rd_data_ff;
            end else begin
               res_kind_in[0] = KIND_NOT_READY;
            end
         end else if (!text_input_ff) begin
            if (!is_full) begin
               mem_we      = 1'b1;
               wr_pos_in   = wr_next;
               byte_cnt_in = byte_cnt_ff + CNT_W'(1);
               if (byte_ff == CH_NL) line_cnt_in = line_cnt_ff + CNT_W'(1);
            end else begin
               err_in = 1'b1;
            end
         end else if (is_nl_cr) begin
            if (!is_full) begin
               mem_we         = 1'b1;
               mem_wdata      = CH_NL;
               wr_pos_in      = wr_next;
               byte_cnt_in    = byte_cnt_ff + CNT_W'(1);
               line_cnt_in    = line_cnt_ff + CNT_W'(1);
               res_kind_in[0] = KIND_ECHO;
               res_data_in[0] = CH_CR;
               res_kind_in[1] = KIND_ECHO;
               res_data_in[1] = CH_NL;
               last_idx_in    = RES_W'(1);
            end else begin
               err_in = 1'b1;
            end
         end else if (is_erase) begin
            // Erase stops at the start of the current line
            if ((byte_cnt_ff != '0) && (rd_data_ff != CH_NL)) begin
               wr_pos_in      = wr_prev;
               byte_cnt_in    = byte_cnt_ff - CNT_W'(1);
               res_kind_in[0] = KIND_ECHO;
               res_data_in[0] = CH_BS;
               res_kind_in[1] = KIND_ECHO;
               res_data_in[1] = CH_SP;
               res_kind_in[2] = KIND_ECHO;
               res_data_in[2] = CH_BS;
               last_idx_in    = RES_W'(2);
            end
         end else begin
            // Keep one slot free for the line end
            if (text_room) begin
               mem_we         = 1'b1;
               wr_pos_in      = wr_next;
               byte_cnt_in    = byte_cnt_ff + CNT_W'(1);
               res_kind_in[0] = KIND_ECHO;
               res_data_in[0] = byte_ff;
            end else begin
               err_in = 1'b1;
            end
         end
      end
   end

   // Advance through the result list
   always_comb begin
      idx_in = idx_ff;
      if (cmd.exec) begin
         idx_in = RES_FIRST;
      end else if (cmd.advance) begin
         idx_in = idx_ff + RES_W'(1);
      end
   end

   // Hold the control state
   always_ff @(posedge clock) begin
      if (reset) begin
         text_input_ff <= 1'b0;
         wr_pos_ff     <= '0;
         rd_pos_ff     <= '0;
         byte_cnt_ff   <= '0;
         line_cnt_ff   <= '0;
         err_ff        <= 1'b0;
         idx_ff        <= RES_FIRST;
         last_idx_ff   <= RES_FIRST;
      end else begin
         if (csr_valid) text_input_ff <= csr_text_input;
         wr_pos_ff   <= wr_pos_in;
         rd_pos_ff   <= rd_pos_in;
         byte_cnt_ff <= byte_cnt_in;
         line_cnt_ff <= line_cnt_in;
         err_ff      <= err_in;
         idx_ff      <= idx_in;
         if (cmd.exec) last_idx_ff <= last_idx_in;
      end
   end

   // Hold the result list
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         for (int i = 0; i < MAX_RES; i++) begin
            res_kind_ff[i] <= res_kind_in[i];
            res_data_ff[i] <= res_data_in[i];
         end
      end
   end

   // Present the current result
   assign sts.at_last         = (idx_ff == last_idx_ff);
   assign rsp_kind            = res_kind_ff[idx_ff];
   assign rsp_data_byte       = res_data_ff[idx_ff];
   assign rsp_last            = sts.at_last;
   assign rsp_overflow_error  = err_ff;
   assign rsp_chars_held      = byte_cnt_ff;
   assign rsp_lines_held      = line_cnt_ff;

endmodule

// ----- hdl/serial_line_discipline_buffer_top.sv -----
// ----------------------------------------------------------------------------
// serial_line_discipline_buffer_top
// Receive line discipline with echo and line editing over a byte ring.
// ----------------------------------------------------------------------------
// Channels: req_chan carries one transaction per received byte (mode 0) or
// per read request (mode 1); rsp_chan returns one to three results per
// transaction, the final one flagged by last; csr_chan writes the text_input
// mode bit and is always ready. Write it only while the block is idle.
// Sequence: the accepting edge fetches the ring byte, the execute state
// then updates the ring state and registers the results, and the emit
// state presents them one by one until the last has been taken.
// Concurrency: one transaction at a time. The single read port of the
// ring memory and the result sequencer set this limit.
// Reset: pointers, counters, the overflow flag and the mode bit clear at
// once; ring contents are not cleared and no clearing pass is needed.
// Stall: a result waits with valid high until rsp ready; no new request is
// taken until the last result of the current transaction has gone.
// ----------------------------------------------------------------------------
module serial_line_discipline_buffer_top
   import sld_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   sld_req_if.sink   req_chan,
   sld_rsp_if.source rsp_chan,
   sld_csr_if.sink   csr_chan
);

   sld_cmd_type cmd;
   sld_sts_type sts;

   // Sequencer
   sld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Ring and result datapath
   sld_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_mode           (req_chan.mode),
      .req_rx_byte        (req_chan.rx_byte),
      .csr_valid          (csr_chan.valid),
      .csr_ready          (csr_chan.ready),
      .csr_text_input     (csr_chan.text_input),
      .rsp_kind           (rsp_chan.kind),
      .rsp_data_byte      (rsp_chan.data_byte),
      .rsp_last           (rsp_chan.last),
      .rsp_overflow_error (rsp_chan.overflow_error),
      .rsp_chars_held     (rsp_chan.chars_held),
      .rsp_lines_held     (rsp_chan.lines_held)
   );

`ifndef ASSERT_OFF
   // Never take a request while results are still being handed out
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request accepted while results pending");

   // Fill level stays within the ring
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.chars_held <= CNT_W'(BUF_DEPTH)))
      else $error("fill level beyond ring depth");

   // Every counted line has its line end held in the ring
   a_lines_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.lines_held <= rsp_chan.chars_held))
      else $error("more lines than bytes held");

   // Overflow flag is sticky
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.overflow_error) |=>
      (!rsp_chan.valid || rsp_chan.overflow_error))
      else $error("overflow flag cleared without reset");
`endif

endmodule
